// ----- design/cmd_pkg.sv -----
package cmd_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    // Quotient bits kept: one more than the data width is enough to decide saturation.
    localparam int Q_BITS     = DATA_WIDTH + 1;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 1;
    localparam int MAG_WIDTH  = PROD_WIDTH;
    localparam int REM_WIDTH  = MAG_WIDTH + FRAC_BITS + Q_BITS;

    typedef enum logic {
        CMD_MUL = 1'b0,
        CMD_DIV = 1'b1
    } t_cmd;

    typedef logic signed [DATA_WIDTH-1:0] t_data;

    typedef struct packed {
        logic                 vld;
        t_cmd                 cmd;
        logic                 dz;
        logic                 mul_ovf;
        t_data                mul_re;
        t_data                mul_im;
        logic                 neg_re;
        logic                 neg_im;
        logic                 big_re;
        logic                 big_im;
        logic [MAG_WIDTH-1:0] den;
        logic [REM_WIDTH-1:0] rem_re;
        logic [REM_WIDTH-1:0] rem_im;
        logic [Q_BITS-1:0]    q_re;
        logic [Q_BITS-1:0]    q_im;
    } t_div_stage;

    typedef struct packed {
        logic  ovf;
        t_data val;
    } t_sat;

    // Clamp a sign and magnitude pair to the signed data range.
    function automatic t_sat saturate(input logic neg, input logic [MAG_WIDTH-1:0] mag);
        t_sat r;
        logic [MAG_WIDTH-1:0] lim;
        lim = MAG_WIDTH'(1) << (DATA_WIDTH - 1);
        if (neg) begin
            r.ovf = (mag > lim);
            r.val = r.ovf ? t_data'(lim) : t_data'(-mag);
        end else begin
            r.ovf = (mag > lim - MAG_WIDTH'(1));
            r.val = r.ovf ? t_data'(lim - MAG_WIDTH'(1)) : t_data'(mag);
        end
        return r;
    endfunction

endpackage

// ----- design/complex_mul_div_unit.sv -----
// Complex multiply / divide on signed Q8.8 operands, fully pipelined.
// Input channel: s_axis. tuser carries the command (0 multiply, 1 divide),
// tdata carries lhs_real, lhs_imag, rhs_real, rhs_imag from bit 0 upward.
// Output channel: m_axis. tdata carries res_real, res_imag; tuser carries
// overflow and div_by_zero. Exactly one output transaction per input.
// An accepted input transaction is loaded into the input register at the
// accepting edge and then passes the product stage, sum stage, preparation
// stage, 17 restoring divider stages (one quotient bit each) and the output
// register before its result is shown.
// Multiply results ride along the divider stages so order is kept.
// One transaction per cycle when not stalled; divider stages set the latency.
// The whole pipeline advances on one enable: when the output register holds a
// result that the receiver does not take, every stage holds and s_axis tready
// drops; nothing is lost or repeated. Empty stages are filled through a stall
// only once the output register is free.
// Synchronous active-low reset clears all valid bits; the payload is not reset.
module complex_mul_div_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // lhs_real, lhs_imag, rhs_real, rhs_imag
    input  logic [63:0] i_s_axis_tdata,
    // cmd
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // res_real, res_imag
    output logic [31:0] o_m_axis_tdata,
    // overflow, div_by_zero
    output logic [1:0]  o_m_axis_tuser
);

    localparam int DW = cmd_pkg::DATA_WIDTH;
    localparam int QB = cmd_pkg::Q_BITS;
    localparam int MW = cmd_pkg::MAG_WIDTH;
    localparam int RW = cmd_pkg::REM_WIDTH;
    localparam int SW = cmd_pkg::SUM_WIDTH;
    localparam int PW = cmd_pkg::PROD_WIDTH;

    logic w_adv;

    // Stage 1: inputs.
    logic               r_v1;
    cmd_pkg::t_cmd      r_cmd1;
    cmd_pkg::t_data     r_a, r_b, r_c, r_d;

    // Stage 2: products.
    logic               r_v2;
    cmd_pkg::t_cmd      r_cmd2;
    logic signed [PW-1:0] r_ac, r_bd, r_ad, r_bc, r_cc, r_dd;

    // Stage 3: sums.
    logic               r_v3;
    cmd_pkg::t_cmd      r_cmd3;
    logic signed [SW-1:0] r_sre, r_sim;
    logic [MW-1:0]      r_den;

    cmd_pkg::t_div_stage r_div [QB+1];
    cmd_pkg::t_div_stage n_div [QB+1];

    logic               r_ov;
    logic [31:0]        r_odata;
    logic [1:0]         r_ouser;

    assign w_adv           = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    // Preparation stage: magnitudes, multiply saturation, divide range check.
    // Restoring divider: stage j decides quotient bit QB-1-j for both parts.
    always_comb begin
        logic [MW-1:0] mre, mim;
        logic [RW-1:0] dsh;
        cmd_pkg::t_sat sre, sim;
        n_div[0] = '0;
        n_div[0].vld    = r_v3;
        n_div[0].cmd    = r_cmd3;
        n_div[0].neg_re = r_sre[SW-1];
        n_div[0].neg_im = r_sim[SW-1];
        mre = MW'(r_sre[SW-1] ? -r_sre : r_sre);
        mim = MW'(r_sim[SW-1] ? -r_sim : r_sim);
        sre = cmd_pkg::saturate(r_sre[SW-1], mre >> cmd_pkg::FRAC_BITS);
        sim = cmd_pkg::saturate(r_sim[SW-1], mim >> cmd_pkg::FRAC_BITS);
        n_div[0].mul_re  = sre.val;
        n_div[0].mul_im  = sim.val;
        n_div[0].mul_ovf = sre.ovf || sim.ovf;
        n_div[0].dz      = (r_cmd3 == cmd_pkg::CMD_DIV) && (r_den == '0);
        n_div[0].den     = r_den;
        // A quotient of 2^QB or more saturates whatever its exact value.
        n_div[0].big_re = ((RW'(mre) << cmd_pkg::FRAC_BITS) >= (RW'(r_den) << QB));
        n_div[0].big_im = ((RW'(mim) << cmd_pkg::FRAC_BITS) >= (RW'(r_den) << QB));
        n_div[0].rem_re = RW'(mre) << cmd_pkg::FRAC_BITS;
        n_div[0].rem_im = RW'(mim) << cmd_pkg::FRAC_BITS;
        n_div[0].q_re   = '0;
        n_div[0].q_im   = '0;

        for (int j = 0; j < QB; j++) begin
            n_div[j+1] = r_div[j];
            dsh = RW'(r_div[j].den) << (QB - 1 - j);
            if (r_div[j].rem_re >= dsh) begin
                n_div[j+1].rem_re = r_div[j].rem_re - dsh;
                n_div[j+1].q_re[QB-1-j] = 1'b1;
            end
            if (r_div[j].rem_im >= dsh) begin
                n_div[j+1].rem_im = r_div[j].rem_im - dsh;
                n_div[j+1].q_im[QB-1-j] = 1'b1;
            end
        end
    end

    cmd_pkg::t_div_stage w_last;
    logic [31:0]         n_odata;
    logic [1:0]          n_ouser;

    always_comb begin
        cmd_pkg::t_sat qre, qim;
        logic [MW-1:0] mre, mim;
        w_last = r_div[QB];
        mre = w_last.big_re ? (MW'(1) << QB) : MW'(w_last.q_re);
        mim = w_last.big_im ? (MW'(1) << QB) : MW'(w_last.q_im);
        qre = cmd_pkg::saturate(w_last.neg_re, mre);
        qim = cmd_pkg::saturate(w_last.neg_im, mim);
        unique case (w_last.cmd)
            cmd_pkg::CMD_MUL: begin
                n_odata = {w_last.mul_im, w_last.mul_re};
                n_ouser = {1'b0, w_last.mul_ovf};
            end
            cmd_pkg::CMD_DIV: begin
                if (w_last.dz) begin
                    n_odata = '0;
                    n_ouser = 2'b10;
                end else begin
                    n_odata = {qim.val, qre.val};
                    n_ouser = {1'b0, qre.ovf || qim.ovf};
                end
            end
            default: begin
                n_odata = '0;
                n_ouser = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
            for (int j = 0; j <= QB; j++) begin
                r_div[j].vld <= 1'b0;
            end
        end else if (w_adv) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= w_last.vld;
            for (int j = 0; j <= QB; j++) begin
                r_div[j] <= n_div[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cmd1 <= cmd_pkg::t_cmd'(i_s_axis_tuser);
            r_a    <= i_s_axis_tdata[DW-1:0];
            r_b    <= i_s_axis_tdata[2*DW-1:DW];
            r_c    <= i_s_axis_tdata[3*DW-1:2*DW];
            r_d    <= i_s_axis_tdata[4*DW-1:3*DW];

            r_cmd2 <= r_cmd1;
            r_ac   <= r_a * r_c;
            r_bd   <= r_b * r_d;
            r_ad   <= r_a * r_d;
            r_bc   <= r_b * r_c;
            r_cc   <= r_c * r_c;
            r_dd   <= r_d * r_d;

            r_cmd3 <= r_cmd2;
            r_den  <= MW'(r_cc) + MW'(r_dd);
            if (r_cmd2 == cmd_pkg::CMD_MUL) begin
                r_sre <= SW'(r_ac) - SW'(r_bd);
                r_sim <= SW'(r_ad) + SW'(r_bc);
            end else begin
                r_sre <= SW'(r_ac) + SW'(r_bd);
                r_sim <= SW'(r_bc) - SW'(r_ad);
            end

            r_odata <= n_odata;
            r_ouser <= n_ouser;
        end
    end

endmodule

// ----- design/cmd_checker.sv -----
module cmd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped during stall");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tdata == 32'd0)
        else $error("divide by zero with nonzero result");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("overflow and divide by zero together");

endmodule

bind complex_mul_div_unit cmd_checker u_cmd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);

// ----- tb/complex_mul_div_unit_tb.sv -----
`timescale 1ns / 100ps

// Queue of predicted results for the complex multiply/divide unit.
class cplx_scoreboard;
    typedef struct {
        logic [15:0] re;
        logic [15:0] im;
        logic        ovf;
        logic        dz;
    } t_result;

    t_result pending[$];
    int      errors;

    // Clamp a sign/magnitude value to 16 bits signed.
    function automatic logic [15:0] clamp(input bit neg, input logic [63:0] mag,
                                          inout bit ovf);
        if (neg) begin
            if (mag > 64'd32768) begin
                ovf = 1'b1;
                mag = 64'd32768;
            end
            return 16'(64'd0 - mag);
        end
        if (mag > 64'd32767) begin
            ovf = 1'b1;
            mag = 64'd32767;
        end
        return 16'(mag);
    endfunction

    // Truncated quotient with 8 fraction bits; huge values are capped.
    function automatic logic [63:0] frac_quot(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        q = num / den;
        if (q > 64'hFFFF) return 64'd1 << 62;
        return (num << 8) / den;
    endfunction

    function void note_operands(input logic cmd, input logic signed [15:0] a,
                                input logic signed [15:0] b, input logic signed [15:0] c,
                                input logic signed [15:0] d);
        t_result r;
        longint sre, sim, den;
        bit ovf;
        ovf = 1'b0;
        r.dz = 1'b0;
        if (cmd == cmd_pkg::CMD_MUL) begin
            sre = longint'(a) * c - longint'(b) * d;
            sim = longint'(a) * d + longint'(b) * c;
            r.re = clamp(sre < 0, (sre < 0 ? -sre : sre) >> 8, ovf);
            r.im = clamp(sim < 0, (sim < 0 ? -sim : sim) >> 8, ovf);
        end else begin
            den = longint'(c) * c + longint'(d) * d;
            if (den == 0) begin
                r.dz = 1'b1;
                r.re = '0;
                r.im = '0;
            end else begin
                sre = longint'(a) * c + longint'(b) * d;
                sim = longint'(b) * c - longint'(a) * d;
                r.re = clamp(sre < 0, frac_quot(sre < 0 ? -sre : sre, den), ovf);
                r.im = clamp(sim < 0, frac_quot(sim < 0 ? -sim : sim, den), ovf);
            end
        end
        r.ovf = ovf;
        pending.push_back(r);
    endfunction

    task report(input string msg);
        $display("%s", msg);
        errors++;
    endtask

    task check_result(input logic [31:0] data, input logic [1:0] flags);
        t_result e;
        if (pending.size() == 0) begin
            report($sformatf("unexpected result %h/%b", data, flags));
            return;
        end
        e = pending.pop_front();
        if (data[15:0] !== e.re || data[31:16] !== e.im || flags[0] !== e.ovf
                || flags[1] !== e.dz) begin
            report($sformatf("mismatch: got re %h im %h ovf %b dz %b, want %h %h %b %b",
                             data[15:0], data[31:16], flags[0], flags[1],
                             e.re, e.im, e.ovf, e.dz));
        end
    endtask
endclass

module complex_mul_div_unit_tb;

    localparam int LATENCY = 22;
    localparam longint CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;

    cplx_scoreboard results;
    longint cycles = 0;
    bit     hold_off;
    bit     sending_done;

    complex_mul_div_unit dut (.*);

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("complex_mul_div_unit_tb: errors");
            $finish;
        end
    end

    task automatic wait_cycles(input int n);
        repeat (n) @(posedge i_clk);
    endtask

    // Leaves tvalid high so that a following transaction can go back to back.
    task automatic send_operands(input cmd_pkg::t_cmd cmd, input logic [15:0] a,
                                 input logic [15:0] b, input logic [15:0] c,
                                 input logic [15:0] d);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {d, c, b, a};
        do @(posedge i_clk); while (!o_s_axis_tready);
        results.note_operands(cmd, a, b, c, d);
    endtask

    task automatic send_idle_then(input cmd_pkg::t_cmd cmd, input logic [15:0] a,
                                  input logic [15:0] b, input logic [15:0] c,
                                  input logic [15:0] d, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 18) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            wait_cycles(gap);
        end
        send_operands(cmd, a, b, c, d);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 1023)) - 512);
            3: return 16'($urandom_range(0, 255)) ^ {16{$urandom_range(0, 1) == 1}};
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: random stalls, with one long hold-off to fill the pipeline.
    initial begin
        int stall;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) stall = 0;
            else stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (cycles > 2000 && cycles < 4000) stall = 0;
            if (stall > 0 || hold_off) begin
                i_m_axis_tready <= 1'b0;
                wait_cycles(stall);
                while (hold_off) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            results.check_result(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    logic [15:0] edge_vals [5] = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0100};

    initial begin
        int idx;
        results = new();
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        wait_cycles(4);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes of both operands under both commands, zero divisor included.
        send_operands(cmd_pkg::CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_operands(cmd_pkg::CMD_MUL, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_operands(cmd_pkg::CMD_MUL, 16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF);
        send_operands(cmd_pkg::CMD_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
        send_operands(cmd_pkg::CMD_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
        send_operands(cmd_pkg::CMD_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_operands(cmd_pkg::CMD_DIV, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h0000);
        send_operands(cmd_pkg::CMD_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_operands(cmd_pkg::CMD_DIV, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000);
        send_operands(cmd_pkg::CMD_DIV, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000);
        send_operands(cmd_pkg::CMD_DIV, 16'h0100, 16'h0100, 16'h0100, 16'hFF00);
        for (idx = 0; idx < 10; idx++)
            send_operands(cmd_pkg::t_cmd'(idx[0]), edge_vals[idx % 5],
                          edge_vals[(idx + 2) % 5], edge_vals[(idx + 1) % 5],
                          edge_vals[(idx + 3) % 5]);

        // Long receiver hold-off while the sender keeps offering.
        hold_off = 1'b1;
        fork
            begin wait_cycles(200); hold_off = 1'b0; end
            for (idx = 0; idx < 40; idx++)
                send_operands(cmd_pkg::t_cmd'($urandom_range(0, 1)), pick_value(),
                              pick_value(), pick_value(), pick_value());
        join

        for (idx = 0; idx < 1000; idx++)
            send_idle_then(cmd_pkg::t_cmd'($urandom_range(0, 1)), pick_value(), pick_value(),
                           ($urandom_range(0, 15) == 0) ? 16'h0000 : pick_value(),
                           ($urandom_range(0, 15) == 0) ? 16'h0000 : pick_value(),
                           !(idx >= 300 && idx < 450));
        i_s_axis_tvalid <= 1'b0;

        while (results.pending.size() != 0) @(posedge i_clk);
        wait_cycles(LATENCY + 10);
        if (results.errors == 0 && results.pending.size() == 0) begin
            $display("complex_mul_div_unit_tb: clean");
        end else begin
            $display("complex_mul_div_unit_tb: errors");
        end
        $finish;
    end
endmodule

// ----- files.f -----
design/cmd_pkg.sv
design/complex_mul_div_unit.sv
design/cmd_checker.sv
tb/complex_mul_div_unit_tb.sv
